// ===== hw/rtl/line_highest_cell_search_defines.svh =====
// Assertion macros for the line highest-cell search block.
`ifndef LINE_HIGHEST_CELL_SEARCH_DEFINES_SVH
`define LINE_HIGHEST_CELL_SEARCH_DEFINES_SVH
`ifndef SYNTHESIS
`define LHCS_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define LHCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LHCS_ASSERT_IMPL(lbl, ante, cons, msg)
`define LHCS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hw/rtl/lhcs_pkg.sv =====
// Types and constants shared by the line highest-cell search modules.
package lhcs_pkg;

  localparam int COORD_W  = 9;
  localparam int DIM_W    = 10;
  localparam int HEIGHT_W = 8;
  localparam int ERR_W    = 11;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  localparam logic CFG_MAP_WIDTH  = 1'b0;
  localparam logic CFG_MAP_HEIGHT = 1'b1;

  typedef struct packed {
    logic                action;
    logic [COORD_W-1:0]  cell_col;
    logic [COORD_W-1:0]  cell_row;
    logic [HEIGHT_W-1:0] cell_height;
    logic [COORD_W-1:0]  start_x;
    logic [COORD_W-1:0]  start_y;
    logic [COORD_W-1:0]  end_x;
    logic [COORD_W-1:0]  end_y;
  } in_beat_t;

  typedef struct packed {
    logic                found;
    logic [HEIGHT_W-1:0] peak_height;
    logic [COORD_W-1:0]  peak_x;
    logic [COORD_W-1:0]  peak_y;
  } out_beat_t;

  typedef struct packed {
    logic               en;
    logic [COORD_W-1:0] col;
    logic [DIM_W-1:0]   row;
  } rd_req_t;

  typedef struct packed {
    logic idle;
    logic done;
  } walk_stat_t;

endpackage

// ===== hw/rtl/lhcs_store.sv =====
// Height grid memory: one write port, one registered read port.
module lhcs_store import lhcs_pkg::*; #(
  parameter int MAP_SIDE = 512
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [COORD_W-1:0]  wr_col,
  input  logic [COORD_W-1:0]  wr_row,
  input  logic [HEIGHT_W-1:0] wr_data,
  input  rd_req_t             rd,
  output logic [HEIGHT_W-1:0] rd_data
);

  localparam int DEPTH = MAP_SIDE * MAP_SIDE;
  localparam int AW    = $clog2(DEPTH);

  logic [HEIGHT_W-1:0] mem [DEPTH];
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       raddr;
  logic                wr_ok;

  assign wr_ok = (int'(wr_col) < MAP_SIDE) && (int'(wr_row) < MAP_SIDE);
  assign waddr = AW'(wr_col) * AW'(MAP_SIDE) + AW'(wr_row);
  assign raddr = AW'(rd.col) * AW'(MAP_SIDE) + AW'(rd.row);

  always_ff @(posedge clk) begin
    if (wr_en && wr_ok) begin
      mem[waddr] <= wr_data;
    end
    if (rd.en) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

// ===== hw/rtl/lhcs_walk.sv =====
// Line walk sequencer: one Bresenham step unit, cell reads and peak compare.
module lhcs_walk import lhcs_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  in_beat_t            beat,
  input  logic [DIM_W-1:0]    map_width,
  input  logic [DIM_W-1:0]    map_height,
  input  logic                take,
  output walk_stat_t          stat,
  output rd_req_t             rd,
  input  logic [HEIGHT_W-1:0] rd_data,
  output out_beat_t           result
);

  typedef enum logic [2:0] {S_IDLE, S_STEP, S_VISIT, S_DRAIN, S_DONE} state_t;

  state_t              state;
  logic                ymaj;
  logic                maj_neg;
  logic                min_neg;
  logic [COORD_W-1:0]  maj;
  logic [COORD_W-1:0]  mnr;
  logic [DIM_W-1:0]    a2;
  logic [DIM_W-1:0]    b2;
  logic [ERR_W-1:0]    err;
  logic [ERR_W-1:0]    prev;
  logic [COORD_W-1:0]  cnt;
  logic [COORD_W-1:0]  pt_x [3];
  logic [COORD_W-1:0]  pt_y [3];
  logic [1:0]          pt_last;
  logic [1:0]          idx;
  logic                pend;
  logic [COORD_W-1:0]  pend_x;
  logic [COORD_W-1:0]  pend_y;
  logic [HEIGHT_W-1:0] best_h;
  logic [COORD_W-1:0]  best_x;
  logic [COORD_W-1:0]  best_y;

  // start setup
  logic               dx_neg, dy_neg, ymaj_s;
  logic [COORD_W-1:0] adx, ady, a_s, b_s;

  always_comb begin
    dx_neg = beat.end_x < beat.start_x;
    dy_neg = beat.end_y < beat.start_y;
    adx    = dx_neg ? beat.start_x - beat.end_x : beat.end_x - beat.start_x;
    ady    = dy_neg ? beat.start_y - beat.end_y : beat.end_y - beat.start_y;
    ymaj_s = ady >= adx;
    a_s    = ymaj_s ? ady : adx;
    b_s    = ymaj_s ? adx : ady;
  end

  // step unit
  logic [COORD_W-1:0] maj_n, mnr_n, mnr_m;
  logic [ERR_W-1:0]   e1, e2, esum;
  logic               diag;
  logic [COORD_W-1:0] ca_x, ca_y, cb_x, cb_y, cm_x, cm_y;
  logic [COORD_W-1:0] st_x [3];
  logic [COORD_W-1:0] st_y [3];
  logic [1:0]         st_last;

  always_comb begin
    maj_n = maj_neg ? maj - COORD_W'(1) : maj + COORD_W'(1);
    mnr_n = min_neg ? mnr - COORD_W'(1) : mnr + COORD_W'(1);
    e1    = err + ERR_W'(b2);
    diag  = e1 > ERR_W'(a2);
    e2    = e1 - ERR_W'(a2);
    esum  = e2 + prev;
    mnr_m = diag ? mnr_n : mnr;
    ca_x  = ymaj ? mnr : maj_n;
    ca_y  = ymaj ? maj_n : mnr;
    cb_x  = ymaj ? mnr_n : maj;
    cb_y  = ymaj ? maj : mnr_n;
    cm_x  = ymaj ? mnr_m : maj_n;
    cm_y  = ymaj ? maj_n : mnr_m;
    st_x[0] = cm_x;
    st_y[0] = cm_y;
    st_x[1] = cm_x;
    st_y[1] = cm_y;
    st_x[2] = cm_x;
    st_y[2] = cm_y;
    st_last = 2'd0;
    priority if (!diag) begin
      st_last = 2'd0;
    end else if (esum < ERR_W'(a2)) begin
      st_x[0] = ca_x;
      st_y[0] = ca_y;
      st_last = 2'd1;
    end else if (esum > ERR_W'(a2)) begin
      st_x[0] = cb_x;
      st_y[0] = cb_y;
      st_last = 2'd1;
    end else begin
      st_x[0] = ca_x;
      st_y[0] = ca_y;
      st_x[1] = cb_x;
      st_y[1] = cb_y;
      st_last = 2'd2;
    end
  end

  // visit address
  logic [COORD_W-1:0] vx, vy;
  logic               in_map;

  always_comb begin
    vx     = pt_x[idx];
    vy     = pt_y[idx];
    in_map = ({1'b0, vx} < map_width) && (vy != '0) && ({1'b0, vy} <= map_height);
    rd.en  = (state == S_VISIT) && in_map;
    rd.col = vx;
    rd.row = map_height - {1'b0, vy};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      pend   <= 1'b0;
      best_h <= '0;
      best_x <= '0;
      best_y <= '0;
    end else begin
      pend <= 1'b0;
      if (pend && (rd_data > best_h)) begin
        best_h <= rd_data;
        best_x <= pend_x;
        best_y <= pend_y;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            best_h  <= '0;
            best_x  <= '0;
            best_y  <= '0;
            ymaj    <= ymaj_s;
            maj_neg <= ymaj_s ? dy_neg : dx_neg;
            min_neg <= ymaj_s ? dx_neg : dy_neg;
            maj     <= ymaj_s ? beat.start_y : beat.start_x;
            mnr     <= ymaj_s ? beat.start_x : beat.start_y;
            a2      <= {a_s, 1'b0};
            b2      <= {b_s, 1'b0};
            err     <= ERR_W'(a_s);
            prev    <= ERR_W'(a_s);
            cnt     <= a_s;
            if (beat.action == ACT_QUERY && a_s != '0) begin
              state <= S_STEP;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_STEP: begin
          maj     <= maj_n;
          mnr     <= mnr_m;
          err     <= diag ? e2 : e1;
          prev    <= diag ? e2 : e1;
          cnt     <= cnt - COORD_W'(1);
          pt_x    <= st_x;
          pt_y    <= st_y;
          pt_last <= st_last;
          idx     <= 2'd0;
          state   <= S_VISIT;
        end
        S_VISIT: begin
          pend   <= in_map;
          pend_x <= vx;
          pend_y <= vy;
          if (idx == pt_last) begin
            state <= (cnt == '0) ? S_DRAIN : S_STEP;
          end else begin
            idx <= idx + 2'd1;
          end
        end
        S_DRAIN: begin
          state <= S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign stat.idle          = (state == S_IDLE);
  assign stat.done          = (state == S_DONE);
  assign result.found       = (best_h != '0);
  assign result.peak_height = best_h;
  assign result.peak_x      = best_x;
  assign result.peak_y      = best_y;

endmodule

// ===== hw/rtl/line_highest_cell_search.sv =====
// Line highest-cell search: top level with handshake, config and output register.
// Write beat: the walk goes straight to done, then the result enters the output register.
// Query: the walk alternates a step state with visits to the line's cells, then drains.
// A new beat is accepted once the result is taken; a held result stalls the walk.
// Sync reset clears control and sets both map dimensions to 512 (capped at MAP_SIDE).
// The height grid is not cleared by reset.
`include "line_highest_cell_search_defines.svh"
module line_highest_cell_search import lhcs_pkg::*; #(
  parameter int MAP_SIDE = 512
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  in_beat_t         in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output out_beat_t        out_data,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [DIM_W-1:0] cfg_data
);

  localparam logic [DIM_W-1:0] DIM_RESET =
      (MAP_SIDE < 512) ? DIM_W'(MAP_SIDE) : DIM_W'(512);

  logic [DIM_W-1:0]    map_width;
  logic [DIM_W-1:0]    map_height;
  logic [DIM_W-1:0]    cfg_dim;
  logic                accept;
  logic                take;
  walk_stat_t          stat;
  rd_req_t             rd;
  logic [HEIGHT_W-1:0] rd_data;
  out_beat_t           result;

  assign cfg_dim  = (int'(cfg_data) > MAP_SIDE) ? DIM_W'(MAP_SIDE) : cfg_data;
  assign in_stall = !stat.idle;
  assign accept   = in_valid && !in_stall;
  assign take     = stat.done && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_RESET;
      map_height <= DIM_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MAP_WIDTH:  map_width  <= cfg_dim;
        CFG_MAP_HEIGHT: map_height <= cfg_dim;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_data <= result;
    end
  end

  lhcs_store #(
    .MAP_SIDE(MAP_SIDE)
  ) u_store (
    .clk    (clk),
    .wr_en  (accept && (in_data.action == ACT_WRITE)),
    .wr_col (in_data.cell_col),
    .wr_row (in_data.cell_row),
    .wr_data(in_data.cell_height),
    .rd     (rd),
    .rd_data(rd_data)
  );

  lhcs_walk u_walk (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .beat      (in_data),
    .map_width (map_width),
    .map_height(map_height),
    .take      (take),
    .stat      (stat),
    .rd        (rd),
    .rd_data   (rd_data),
    .result    (result)
  );

  `LHCS_ASSERT_NEXT(a_busy_after_accept, accept, in_stall, "idle right after accepting a beat")
  `LHCS_ASSERT_IMPL(a_read_only_busy, rd.en, in_stall, "grid read while idle")
  `LHCS_ASSERT_IMPL(a_found_matches, out_valid, out_data.found == |out_data.peak_height, "found flag off")
  `LHCS_ASSERT_NEXT(a_take_holds_slot, take, out_valid, "result lost at output register")

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the line highest-cell search block: scoreboard, drivers, phases.
module tb_top;
  import lhcs_pkg::*;

  localparam int GRID        = 512;
  localparam int LIMIT       = 4_000_000;
  localparam int PHASES      = 9;
  localparam int PHASE_ITEMS = 58;
  localparam int FILL_MAX    = 40;

  class peak_board;
    bit [HEIGHT_W-1:0] heights [GRID*GRID];
    bit                written [GRID*GRID];
    int                cols_used = GRID;
    int                rows_used = GRID;
    int                best_h;
    int                best_x;
    int                best_y;
    bit                probing;
    int                missing [$];
    out_beat_t         peaks_due [$];
    int                errors;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function void set_dim(logic idx, logic [DIM_W-1:0] value);
      int v;
      v = (value > GRID) ? GRID : int'(value);
      if (idx == CFG_MAP_WIDTH) cols_used = v;
      else rows_used = v;
    endfunction

    function void visit_cell(int x, int y);
      int idx;
      if (x < 0 || x >= cols_used || y < 1 || y > rows_used) return;
      idx = x * GRID + (rows_used - y);
      if (probing) begin
        if (!written[idx]) missing.push_back(idx);
      end else if (int'(heights[idx]) > best_h) begin
        best_h = heights[idx];
        best_x = x;
        best_y = y;
      end
    endfunction

    // supercover walk; corner cells go before the main cell on a diagonal step
    function void walk_line(int x1, int y1, int x2, int y2);
      int x, y, dx, dy, sx, sy, ddx, ddy, err, prev;
      x = x1;
      y = y1;
      dx = x2 - x1;
      dy = y2 - y1;
      sx = 1;
      sy = 1;
      if (dx < 0) begin
        sx = -1;
        dx = -dx;
      end
      if (dy < 0) begin
        sy = -1;
        dy = -dy;
      end
      ddx = 2 * dx;
      ddy = 2 * dy;
      if (ddy >= ddx) begin
        err = dy;
        prev = dy;
        for (int i = 0; i < dy; i++) begin
          y += sy;
          err += ddx;
          if (err > ddy) begin
            x += sx;
            err -= ddy;
            if (err + prev < ddy) begin
              visit_cell(x - sx, y);
            end else if (err + prev > ddy) begin
              visit_cell(x, y - sy);
            end else begin
              visit_cell(x - sx, y);
              visit_cell(x, y - sy);
            end
          end
          visit_cell(x, y);
          prev = err;
        end
      end else begin
        err = dx;
        prev = dx;
        for (int i = 0; i < dx; i++) begin
          x += sx;
          err += ddy;
          if (err > ddx) begin
            y += sy;
            err -= ddx;
            if (err + prev < ddx) begin
              visit_cell(x, y - sy);
            end else if (err + prev > ddx) begin
              visit_cell(x - sx, y);
            end else begin
              visit_cell(x, y - sy);
              visit_cell(x - sx, y);
            end
          end
          visit_cell(x, y);
          prev = err;
        end
      end
    endfunction

    // cells a query would read that hold no written height yet
    function void find_missing(in_beat_t b);
      probing = 1'b1;
      missing.delete();
      walk_line(int'(b.start_x), int'(b.start_y), int'(b.end_x), int'(b.end_y));
      probing = 1'b0;
    endfunction

    function void note_beat(in_beat_t b);
      out_beat_t e;
      int idx;
      e = '0;
      if (b.action == ACT_WRITE) begin
        idx = int'(b.cell_col) * GRID + int'(b.cell_row);
        heights[idx] = b.cell_height;
        written[idx] = 1'b1;
      end else begin
        best_h = 0;
        best_x = 0;
        best_y = 0;
        walk_line(int'(b.start_x), int'(b.start_y), int'(b.end_x), int'(b.end_y));
        if (best_h > 0) begin
          e.found = 1'b1;
          e.peak_height = best_h[HEIGHT_W-1:0];
          e.peak_x = best_x[COORD_W-1:0];
          e.peak_y = best_y[COORD_W-1:0];
        end
      end
      peaks_due.push_back(e);
    endfunction

    task check_peak(out_beat_t got);
      out_beat_t e;
      if (peaks_due.size() == 0) begin
        report($sformatf("result beat with nothing due: %h", got));
        return;
      end
      e = peaks_due.pop_front();
      if (got.found !== e.found)
        report($sformatf("found %b, want %b", got.found, e.found));
      if (got.peak_height !== e.peak_height)
        report($sformatf("peak_height %0d, want %0d", got.peak_height, e.peak_height));
      if (got.peak_x !== e.peak_x)
        report($sformatf("peak_x %0d, want %0d", got.peak_x, e.peak_x));
      if (got.peak_y !== e.peak_y)
        report($sformatf("peak_y %0d, want %0d", got.peak_y, e.peak_y));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  in_beat_t         in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  out_beat_t        out_data;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_MAP_WIDTH;
  logic [DIM_W-1:0] cfg_data = '0;

  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_ask = 0;
  int        hold_left = 0;
  int        cycles = 0;
  int        sent = 0;
  peak_board board;

  line_highest_cell_search #(.MAP_SIDE(GRID)) u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // receiver: random stall, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_ask > 0) begin
      hold_left = hold_ask;
      hold_ask = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) board.check_peak(out_data);
  end

  function automatic int rand_height();
    case ($urandom_range(3))
      0: return 0;
      1: return $urandom_range(3, 1);
      default: return $urandom_range(255);
    endcase
  endfunction

  function automatic in_beat_t rand_beat();
    in_beat_t b;
    b.action = 1'($urandom_range(1));
    b.cell_col = COORD_W'($urandom_range(GRID - 1));
    b.cell_row = COORD_W'($urandom_range(GRID - 1));
    b.cell_height = HEIGHT_W'($urandom_range(255));
    b.start_x = COORD_W'($urandom_range(GRID - 1));
    b.start_y = COORD_W'($urandom_range(GRID - 1));
    b.end_x = COORD_W'($urandom_range(GRID - 1));
    b.end_y = COORD_W'($urandom_range(GRID - 1));
    return b;
  endfunction

  function automatic int near(int span);
    if ($urandom_range(99) < 15) return $urandom_range(GRID - 1);
    return $urandom_range((span + 1 > GRID - 1) ? GRID - 1 : span + 1);
  endfunction

  function automatic int clip(int v);
    return (v < 0) ? 0 : ((v > GRID - 1) ? GRID - 1 : v);
  endfunction

  // number of cells that would need a write before this query may go out
  function automatic int fill_cost(int x1, int y1, int x2, int y2);
    in_beat_t b;
    b = '0;
    b.action = ACT_QUERY;
    b.start_x = COORD_W'(x1);
    b.start_y = COORD_W'(y1);
    b.end_x = COORD_W'(x2);
    b.end_y = COORD_W'(y2);
    board.find_missing(b);
    return board.missing.size();
  endfunction

  task automatic send_beat(in_beat_t b);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    board.note_beat(b);
    sent++;
  endtask

  task automatic put_cell(int col, int row, int h);
    in_beat_t b;
    b = rand_beat();
    b.action = ACT_WRITE;
    b.cell_col = COORD_W'(col);
    b.cell_row = COORD_W'(row);
    b.cell_height = HEIGHT_W'(h);
    send_beat(b);
  endtask

  // fills any unwritten cell on the line before the query goes out
  task automatic run_query(int x1, int y1, int x2, int y2);
    in_beat_t b;
    int need [$];
    b = rand_beat();
    b.action = ACT_QUERY;
    b.start_x = COORD_W'(x1);
    b.start_y = COORD_W'(y1);
    b.end_x = COORD_W'(x2);
    b.end_y = COORD_W'(y2);
    board.find_missing(b);
    need = board.missing;
    foreach (need[i]) put_cell(need[i] / GRID, need[i] % GRID, rand_height());
    send_beat(b);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (board.peaks_due.size() != 0);
  endtask

  task automatic write_cfg(logic idx, int value);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= DIM_W'(value);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_dim(idx, DIM_W'(value));
  endtask

  task automatic random_item();
    int x1, y1, x2, y2, cols, rows;
    bit long_line;
    cols = board.cols_used;
    rows = board.rows_used;
    if ($urandom_range(3) == 0) begin
      if ($urandom_range(4) == 0)
        put_cell($urandom_range(GRID - 1), $urandom_range(GRID - 1), rand_height());
      else
        put_cell($urandom_range(cols - 1), $urandom_range(rows - 1), rand_height());
    end else begin
      x1 = near(cols);
      y1 = near(rows);
      long_line = ($urandom_range(99) < ((cols * rows > 4096) ? 2 : 10));
      if (long_line) begin
        x2 = $urandom_range(GRID - 1);
        y2 = $urandom_range(GRID - 1);
        long_line = (fill_cost(x1, y1, x2, y2) <= FILL_MAX);
      end
      if (!long_line) begin
        x2 = clip(x1 + int'($urandom_range(16)) - 8);
        y2 = clip(y1 + int'($urandom_range(16)) - 8);
      end
      run_query(x1, y1, x2, y2);
    end
  endtask

  initial begin
    int w, h, phase_end;
    board = new();
    idle_pct = 13;
    stall_pct = 70;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // 2x2 map: logical y 1 reads stored row 1, y 2 reads row 0
    write_cfg(CFG_MAP_WIDTH, 2);
    write_cfg(CFG_MAP_HEIGHT, 2);
    put_cell(0, 0, 5);
    put_cell(0, 1, 5);
    put_cell(1, 0, 255);
    put_cell(1, 1, 0);
    put_cell(511, 511, 255);
    run_query(0, 0, 0, 0);
    run_query(511, 511, 511, 511);
    run_query(0, 0, 0, 3);
    run_query(0, 3, 0, 0);
    run_query(0, 0, 2, 2);
    run_query(2, 2, 0, 0);
    run_query(3, 1, 0, 2);
    run_query(0, 2, 2, 1);
    run_query(0, 1, 511, 2);
    run_query(511, 511, 0, 0);
    run_query(511, 0, 0, 511);
    run_query(100, 100, 110, 120);
    run_query(1, 0, 1, 1);

    for (int p = 0; p < PHASES; p++) begin
      case (p / 3)
        0: begin
          idle_pct = 13;
          stall_pct = 70;
        end
        1: begin
          idle_pct = 70;
          stall_pct = 13;
        end
        default: begin
          idle_pct = 0;
          stall_pct = 0;
        end
      endcase
      case (p)
        0: begin
          w = 1;
          h = 1;
        end
        1: begin
          w = 512;
          h = 512;
        end
        2: begin
          w = 1023;
          h = 9;
        end
        3: begin
          w = $urandom_range(16, 2);
          h = $urandom_range(16, 2);
        end
        4: begin
          w = 512;
          h = 1;
        end
        5: begin
          w = 1;
          h = 1023;
        end
        6: begin
          w = $urandom_range(64, 1);
          h = $urandom_range(64, 1);
        end
        7: begin
          w = 600;
          h = 300;
        end
        default: begin
          w = $urandom_range(1023, 513);
          h = $urandom_range(32, 2);
        end
      endcase
      write_cfg(CFG_MAP_WIDTH, w);
      write_cfg(CFG_MAP_HEIGHT, h);
      if (p == 3) begin
        // long output hold-off while writes keep coming, so the input backs up
        hold_ask = 400;
        repeat (8) put_cell($urandom_range(board.cols_used - 1),
                            $urandom_range(board.rows_used - 1), rand_height());
      end
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) random_item();
    end

    drain();
    repeat (2100) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lhcs_pkg.sv
hw/rtl/lhcs_store.sv
hw/rtl/lhcs_walk.sv
hw/rtl/line_highest_cell_search.sv
sim/tb_top.sv
